// ----- hdl/b32e_pkg.sv -----
// ----------------------------------------------------------------------------
// b32e_pkg: shared types and constants of the base32 stream encoder
// Holds the group descriptor passed from the byte collector to the
// character sequencer, the character codes and the alphabet lookup.
// ----------------------------------------------------------------------------
package b32e_pkg;

    localparam int GROUP_BYTES = 5;
    localparam int GROUP_BITS  = 8 * GROUP_BYTES;

    localparam logic [7:0]  CHAR_NL      = 8'h0A;
    localparam logic [7:0]  CHAR_PAD     = 8'h3D;
    localparam logic [15:0] WRAP_RESET   = 16'd76;
    localparam logic [15:0] COLUMN_MAX   = 16'hFFFF;
    localparam logic [2:0]  LAST_CHAR_IX = 3'd7;

    // Register index of the wrap width register.
    localparam logic REG_WRAP = 1'b0;

    // One group of up to five bytes, left aligned, with its character count.
    typedef struct packed {
        logic [GROUP_BITS-1:0] data;
        logic [3:0]            data_chars;
        logic                  last;
    } job_t;

    // Map a 5-bit value onto the upper-case base32 alphabet.
    function automatic logic [7:0] b32_char(input logic [4:0] val);
        logic [7:0] ch;
        if (val < 5'd26)
        begin
            ch = 8'h41 + {3'b000, val};
        end
        else
        begin
            ch = 8'h32 + {3'b000, val} - 8'd26;
        end
        return ch;
    endfunction

    // Number of characters that carry data bits for a group of n bytes.
    function automatic logic [3:0] data_chars_of(input logic [2:0] n);
        logic [3:0] nd;
        case (n)
            3'd1:    nd = 4'd2;
            3'd2:    nd = 4'd4;
            3'd3:    nd = 4'd5;
            3'd4:    nd = 4'd7;
            3'd5:    nd = 4'd8;
            default: nd = 4'd0;
        endcase
        return nd;
    endfunction

endpackage

// ----- hdl/b32e_front.sv -----
// ----------------------------------------------------------------------------
// b32e_front: byte collector
// Accepts one byte per transfer, gathers bytes into groups of five and
// hands a complete or final group to the queue as one descriptor.
// ----------------------------------------------------------------------------
module b32e_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output b32e_pkg::job_t    push_job,
    input  logic              queue_full
);
    import b32e_pkg::*;

    logic [31:0] held_bytes_reg;
    logic [31:0] held_bytes_next;
    logic [2:0]  held_count_reg;
    logic [2:0]  held_count_next;
    logic        accept;
    logic [2:0]  n;
    logic [GROUP_BITS-1:0] wide;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign n        = held_count_reg + 3'd1;
    assign wide     = {held_bytes_reg, in_byte};
    assign push     = accept && ((n == 3'd5) || in_last);

    // Left-align the group so the first byte sits in the top bits.
    always_comb
    begin
        case (n)
            3'd1:    push_job.data = wide << 32;
            3'd2:    push_job.data = wide << 24;
            3'd3:    push_job.data = wide << 16;
            3'd4:    push_job.data = wide << 8;
            default: push_job.data = wide;
        endcase
        push_job.data_chars = data_chars_of(n);
        push_job.last       = in_last;
    end

    // Collect bytes until a group closes, then start over.
    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (push)
        begin
            held_bytes_next = '0;
            held_count_next = '0;
        end
        else if (accept)
        begin
            held_bytes_next = {held_bytes_reg[23:0], in_byte};
            held_count_next = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// ----- hdl/b32e_queue.sv -----
// ----------------------------------------------------------------------------
// b32e_queue: group descriptor queue
// A short first-in first-out queue that decouples the byte collector from
// the character sequencer.
// ----------------------------------------------------------------------------
module b32e_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b32e_pkg::job_t    push_job,
    input  logic              pop,
    output b32e_pkg::job_t    pop_job,
    output logic              full,
    output logic              empty
);
    import b32e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    job_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entries_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue level exceeds depth");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("push into a full queue");
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue level did not follow a push");
`endif

endmodule

// ----- hdl/b32e_back.sv -----
// ----------------------------------------------------------------------------
// b32e_back: character sequencer
// Takes one group descriptor at a time and sends its eight characters,
// wrap newlines and the end-of-stream newline, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module b32e_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       wrap_columns,
    input  logic              job_empty,
    input  b32e_pkg::job_t    job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              out_last
);
    import b32e_pkg::*;

    typedef enum logic [1:0] {
        PH_CHAR,
        PH_WRAP_NL,
        PH_FINAL_NL
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [GROUP_BITS-1:0] data_reg;
    logic [GROUP_BITS-1:0] data_next;
    logic [3:0]            nd_reg;
    logic [3:0]            nd_next;
    logic                  last_reg;
    logic                  last_next;
    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;
    logic [15:0]           col_reg;
    logic [15:0]           col_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  olast_reg;
    logic                  olast_next;

    logic        slot_free;
    logic        step;
    logic [7:0]  cur_char;
    logic [15:0] col_inc;
    logic        wrap_hit;

    assign slot_free = !valid_reg || out_ready;
    assign pop       = !busy_reg && !job_empty;
    assign step      = busy_reg && slot_free;
    assign cur_char  = ({1'b0, idx_reg} < nd_reg) ?
                       b32_char(data_reg[GROUP_BITS-1 -: 5]) : CHAR_PAD;
    assign col_inc   = (col_reg == COLUMN_MAX) ? col_reg : col_reg + 16'd1;
    assign wrap_hit  = (wrap_columns != '0) && (col_inc >= wrap_columns);

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = olast_reg;

    // Sequencer: one character or newline per step.
    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        data_next  = data_reg;
        nd_next    = nd_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        olast_next = olast_reg;

        if (pop)
        begin
            data_next  = job.data;
            nd_next    = job.data_chars;
            last_next  = job.last;
            idx_next   = '0;
            phase_next = PH_CHAR;
            busy_next  = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b1;
            olast_next = 1'b0;
            case (phase_reg)
                PH_CHAR:
                begin
                    char_next = cur_char;
                    data_next = data_reg << 5;
                    if (wrap_hit)
                    begin
                        col_next   = '0;
                        phase_next = PH_WRAP_NL;
                    end
                    else
                    begin
                        col_next = col_inc;
                        if (idx_reg == LAST_CHAR_IX)
                        begin
                            if (last_reg)
                            begin
                                phase_next = PH_FINAL_NL;
                            end
                            else
                            begin
                                olast_next = 1'b1;
                                busy_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
                PH_WRAP_NL:
                begin
                    char_next = CHAR_NL;
                    if (idx_reg == LAST_CHAR_IX)
                    begin
                        olast_next = 1'b1;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        phase_next = PH_CHAR;
                    end
                end
                PH_FINAL_NL:
                begin
                    char_next  = CHAR_NL;
                    col_next   = '0;
                    olast_next = 1'b1;
                    busy_next  = 1'b0;
                end
                default:
                begin
                    phase_next = PH_CHAR;
                    busy_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CHAR;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
            olast_reg <= 1'b0;
            nd_reg    <= '0;
            last_reg  <= 1'b0;
            data_reg  <= '0;
            char_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
            olast_reg <= olast_next;
            nd_reg    <= nd_next;
            last_reg  <= last_next;
            data_reg  <= data_next;
            char_reg  <= char_next;
        end
    end

`ifndef SYNTHESIS
    a_final_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_FINAL_NL) |=> (col_reg == '0 && !busy_reg))
        else $error("end-of-stream newline did not clear the column");
    a_wrap_nl_char: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_WRAP_NL) |=> (valid_reg && char_reg == CHAR_NL))
        else $error("wrap step did not send a newline");
    a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !busy_next) |=> (valid_reg && olast_reg))
        else $error("group finished without a last marker");
`endif

endmodule

// ----- hdl/base32_stream_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base32_stream_encoder_top: streaming base32 encoder with line wrapping
// Input stream: one raw byte per transfer, tlast on the final byte of a
// stream. Output stream: one ASCII character per transfer (alphabet letter,
// '=' padding or newline), tlast on the final character caused by an input
// byte. The APB port holds wrap_columns at address 0 (0 turns wrapping off).
// A byte that does not close a group of five produces nothing; a closing or
// final byte produces eight characters plus wrap newlines and, at the end of
// a stream, a newline when the line is not empty.
// The closing byte's group passes through the group queue and a load step in
// the sequencer before its first character reaches the output register.
// The sequencer sends one character per cycle while the receiver is ready
// and loads each group in a separate step before sending its characters.
// Reset clears all stream state and sets wrap_columns to 76.
// When the receiver stalls, the output register holds its character, the
// group queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module base32_stream_encoder_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast
);
    import b32e_pkg::*;

    logic [15:0] wrap_columns_reg;
    logic [15:0] wrap_columns_next;
    logic        cfg_write;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    job_t        push_job;
    job_t        pop_job;

    // Register file: a single wrap width register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WRAP) ? {16'd0, wrap_columns_reg} : '0;

    always_comb
    begin
        wrap_columns_next = wrap_columns_reg;
        if (cfg_write && paddr[2] == REG_WRAP)
        begin
            wrap_columns_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_columns_reg <= WRAP_RESET;
        end
        else
        begin
            wrap_columns_reg <= wrap_columns_next;
        end
    end

    // Byte collector.
    b32e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    // Group queue between collector and sequencer.
    b32e_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Character sequencer with output register.
    b32e_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wrap_columns (wrap_columns_reg),
        .job_empty    (queue_empty),
        .job          (pop_job),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_char     (m_axis_tdata),
        .out_last     (m_axis_tlast)
    );

endmodule

// ----- tb/base32_stream_encoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base32_stream_encoder_top_test: self-checking bench for the base32 encoder
// Streams random and hand-picked bytes into the encoder under three pacing
// phases. A scoreboard predicts every output character, padding and newline
// and compares each output transfer against it. The wrap register is
// exercised over its full range, including values written mid-line.
// ----------------------------------------------------------------------------
module base32_stream_encoder_top_test;
    import b32e_pkg::*;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 12;
    localparam int DRAIN_PAUSE       = 12;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int BYTES_PER_SETTING = 12;
    localparam int SHOWN_MISMATCHES  = 10;

    // Byte addresses on the configuration port.
    localparam logic [2:0] WRAP_ADDR   = {REG_WRAP, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    // Predicts the encoded character stream and checks the output against it.
    class b32_scoreboard;
        string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
        logic [15:0] wrap_cols;
        logic [31:0] held_bytes;
        int unsigned held_n;
        logic [15:0] column;
        logic [8:0]  pending_chars[$];   // {last, char}
        logic [7:0]  burst[$];
        int unsigned mismatches;
        int unsigned bytes_seen;
        int unsigned streams_seen;
        int unsigned chars_checked;

        function new();
            wrap_cols     = WRAP_RESET;
            held_bytes    = '0;
            held_n        = 0;
            column        = '0;
            mismatches    = 0;
            bytes_seen    = 0;
            streams_seen  = 0;
            chars_checked = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
            begin
                $display("%0t: MISMATCH %s", $time, msg);
            end
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] val);
            if (addr == WRAP_ADDR)
            begin
                wrap_cols = val[15:0];
            end
        endfunction

        function void check_wrap(logic [31:0] rd);
            if (rd !== {16'h0000, wrap_cols})
            begin
                flag($sformatf("wrap readback: expected %0d, got %0d", wrap_cols, rd));
            end
        endfunction

        // One character onto the line, with a newline once the line is full.
        function void put_char(logic [7:0] code);
            burst.push_back(code);
            if (column != COLUMN_MAX)
            begin
                column++;
            end
            if (wrap_cols != 0 && column >= wrap_cols)
            begin
                burst.push_back(CHAR_NL);
                column = '0;
            end
        endfunction

        // Note an accepted input byte and queue the characters it produces.
        function void note_byte(logic [7:0] data, logic last);
            logic [39:0] grp;
            int unsigned n;
            int unsigned nd;
            n = held_n + 1;
            bytes_seen++;
            if (n < GROUP_BYTES && !last)
            begin
                held_bytes = {held_bytes[23:0], data};
                held_n = n;
                return;
            end
            // Left-align the group; missing bytes read as zero.
            grp = {held_bytes, data};
            grp = grp << (8 * (GROUP_BYTES - n));
            // Characters needed to carry 8*n bits; the rest become padding.
            nd = (8 * n + 4) / 5;
            burst.delete();
            for (int i = 0; i < 8; i++)
            begin
                if (i < nd)
                begin
                    put_char(alphabet[grp[39 - 5 * i -: 5]]);
                end
                else
                begin
                    put_char(CHAR_PAD);
                end
            end
            held_bytes = '0;
            held_n = 0;
            if (last)
            begin
                streams_seen++;
                if (column != 0)
                begin
                    burst.push_back(CHAR_NL);
                end
                column = '0;
            end
            foreach (burst[i])
            begin
                pending_chars.push_back({i == burst.size() - 1, burst[i]});
            end
        endfunction

        // Compare one output transfer with the oldest expected character.
        function void check_char(logic [7:0] code, logic last);
            logic [8:0] want;
            if (pending_chars.size() == 0)
            begin
                flag($sformatf("unexpected char %02h last %0b", code, last));
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (want[7:0] !== code || want[8] !== last)
            begin
                flag($sformatf("expected char %02h last %0b, got char %02h last %0b",
                               want[7:0], want[8], code, last));
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction

        function void close_out();
            if (pending_chars.size() != 0)
            begin
                flag($sformatf("%0d characters never arrived", pending_chars.size()));
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_char
    logic        m_axis_tlast;

    b32_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          reg_writes    = 0;
    int unsigned cycle_count   = 0;

    base32_stream_encoder_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run exceeded %0d cycles", CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Send one byte; called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(data, last);
        @(negedge clk);
    endtask

    task automatic send_stream(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Stop sending, wait for all expected characters, then let the pipe settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // Setup and access phase of a register write, then the bus returns to idle.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(addr, val);
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Read the wrap register back and compare it with the predicted value.
    task automatic check_wrap_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WRAP_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.check_wrap(prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_wrap(input logic [15:0] cols);
        quiesce();
        // Upper data bits are random and must be dropped by the register.
        reg_write(WRAP_ADDR, {16'($urandom), cols});
        check_wrap_reg();
    endtask

    // Wrap widths visited by the random part, extremes included.
    function automatic logic [15:0] wrap_for_step(input int step);
        logic [15:0] cols;
        case (step)
            0:       cols = 16'd1;
            1:       cols = 16'd9;
            2:       cols = 16'd0;
            3:       cols = 16'hFFFF;
            4:       cols = 16'd2;
            5:       cols = 16'd76;
            6:       cols = 16'($urandom_range(3, 30));
            7:       cols = 16'd1;
            8:       cols = 16'd5;
            9:       cols = 16'd0;
            10:      cols = 16'd40;
            default: cols = 16'($urandom_range(1, 100));
        endcase
        return cols;
    endfunction

    // Main stimulus.
    initial
    begin
        int sent;
        int len;
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 72;

        // Reset value, then a write to an unmapped address that must be ignored.
        check_wrap_reg();
        reg_write(UNUSED_ADDR, $urandom);
        check_wrap_reg();

        // Every partial group size, with all-zero and all-one bytes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_stream(3);
        send_stream(4);
        send_stream(5);

        // One full group plus two held bytes, then the wrap is lowered below
        // the current column; held bytes must survive the register write.
        for (int i = 0; i < 7; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        set_wrap(16'd3);
        send_byte(8'($urandom_range(0, 255)), 1'b1);

        // Random streams over three pacing phases and several wrap widths.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++)
            begin
                set_wrap(wrap_for_step(ph * 4 + k));
                sent = 0;
                while (sent < BYTES_PER_SETTING)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        len = $urandom_range(1, 4);
                    end
                    else
                    begin
                        len = $urandom_range(5, 16);
                    end
                    send_stream(len);
                    sent += len;
                end
            end
        end

        quiesce();
        sb.close_out();

        $display("Covered %0d bytes in %0d streams, %0d characters checked, %0d register writes.",
                 sb.bytes_seen, sb.streams_seen, sb.chars_checked, reg_writes);
        $display("Pacing: sender/receiver gaps 11/72, 72/11 and none; wrap widths 0 to 65535.");
        if (sb.mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
